// ===== hw/rtl/scg_pkg.sv =====
package scg_pkg;

  localparam int SampleW   = 16;
  localparam int AccW      = 32;
  localparam int RadW      = 34;            // 327680 * 32768 needs 34 bits
  localparam int RootW     = RadW / 2;
  localparam int RemW      = RootW + 2;
  localparam int SqrtSteps = RootW;
  localparam int CntW      = $clog2(SqrtSteps);

  localparam logic [AccW-1:0] FireThresholdReset = 32'd16384000;

  localparam logic [2:0] AddrFireThreshold = 3'd0;
  localparam logic [2:0] AddrLinkChannels  = 3'd4;

  typedef struct packed {
    logic signed [SampleW-1:0] left_sample;
    logic signed [SampleW-1:0] right_sample;
  } scg_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_out;
    logic signed [SampleW-1:0] right_out;
  } scg_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_FIRE,
    ST_SQRT,
    ST_WRITE
  } scg_state_t;

  // magnitude of a q1.15 sample, -32768 gives 32768
  function automatic logic [SampleW-1:0] mag16(input logic signed [SampleW-1:0] x);
    logic [SampleW-1:0] m;
    m = x[SampleW-1] ? (~x + 1'b1) : x;
    return m;
  endfunction

endpackage

// ===== hw/rtl/stereo_click_generator.sv =====
// stereo click generator
//
// input channel: one beat per stereo q1.15 pair on in_data, taken when in_valid
// is high and in_stall is low. result channel: one beat per input beat on
// out_data, offered with out_valid and held until out_stall is low.
// each channel accumulates sample magnitude (saturating at 32 bits); when an
// accumulator reaches fire_threshold it clears and that sample is reshaped to
// sign(x)*floor(sqrt(327680*|x|)), clamped to the q1.15 range. with
// link_channels set a firing on either side fires both.
// an item is taken in the idle state, then passes through an accumulate state,
// a compare state, 17 square root steps per channel on the single shared
// restoring root unit, and an output load state.
// in_stall stays high while an item is in work. a finished result sits in the
// output register, so the next beat is taken while it waits; if out_stall
// holds, the block parks before the output load until the register frees.
// reset (rst_n low, synchronous) clears both accumulators, drops out_valid and
// returns fire_threshold to 16384000 and link_channels to 0.
// config: apb style, fire_threshold at 0x0, link_channels at 0x4, no wait
// states; write only while no beat is in work.
module stereo_click_generator
  import scg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  scg_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output scg_out_t            out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // control state
  scg_state_t       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             chan_r, chan_nxt;
  logic             fire_l_r, fire_l_nxt;
  logic             fire_r_r, fire_r_nxt;
  logic [AccW-1:0]  left_acc_r, left_acc_nxt;
  logic [AccW-1:0]  right_acc_r, right_acc_nxt;
  logic [AccW-1:0]  thr_r;
  logic             link_r;

  // payload
  scg_in_t          smp_r, smp_nxt;
  scg_out_t         out_r, out_nxt;
  logic [SampleW-1:0] shp_l_r, shp_l_nxt;
  logic [SampleW-1:0] shp_r_r, shp_r_nxt;

  // shared root unit
  logic [RadW-1:0]  rad_r, rad_nxt;
  logic [RemW-1:0]  rem_r, rem_nxt;
  logic [RootW-1:0] root_r, root_nxt;

  logic             in_acc;
  logic             out_free;
  logic             sqrt_last;
  logic             cfg_wr;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign sqrt_last = (cnt_r == CntW'(SqrtSteps - 1));
  assign cfg_wr    = psel && penable && pwrite && pready;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_FIRE;
      ST_FIRE:  state_nxt = ST_SQRT;
      ST_SQRT:  if (sqrt_last && chan_r) state_nxt = ST_WRITE;
      ST_WRITE: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  function automatic logic [RadW-1:0] load_rad(input logic signed [SampleW-1:0] x);
    logic [SampleW-1:0] m;
    logic [SampleW+1:0] m5;
    m  = mag16(x);
    m5 = {m, 2'b00} + {2'b00, m};        // 5*|x|, the 65536 factor is the shift
    return {m5, 16'b0};
  endfunction

  logic [AccW:0]      sum_l, sum_r;
  logic [RemW+1:0]    rem_sh;
  logic [RemW+1:0]    trial;
  logic [RootW-1:0]   root_fin;
  logic signed [SampleW-1:0] cur_x;
  logic [SampleW-1:0] shaped;
  logic [RootW-1:0]   root_neg;
  logic               fl, fr;

  always_comb begin
    sum_l = {1'b0, left_acc_r}  + {{(AccW-SampleW+1){1'b0}}, mag16(smp_r.left_sample)};
    sum_r = {1'b0, right_acc_r} + {{(AccW-SampleW+1){1'b0}}, mag16(smp_r.right_sample)};

    fl = (left_acc_r  >= thr_r);
    fr = (right_acc_r >= thr_r);
    if (link_r) begin
      fl = fl || fr;
      fr = fl;
    end

    // one restoring step: two radicand bits in, one root bit out
    rem_sh   = {rem_r, rad_r[RadW-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    root_fin = (rem_sh >= trial) ? {root_r[RootW-2:0], 1'b1} : {root_r[RootW-2:0], 1'b0};

    cur_x    = chan_r ? smp_r.right_sample : smp_r.left_sample;
    root_neg = ~root_fin + 1'b1;
    if (cur_x[SampleW-1]) begin
      shaped = (root_fin > RootW'(32768)) ? 16'h8000 : root_neg[SampleW-1:0];
    end else begin
      shaped = (root_fin > RootW'(32767)) ? 16'h7fff : root_fin[SampleW-1:0];
    end
  end

  always_comb begin
    smp_nxt       = smp_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    cnt_nxt       = cnt_r;
    chan_nxt      = chan_r;
    fire_l_nxt    = fire_l_r;
    fire_r_nxt    = fire_r_r;
    left_acc_nxt  = left_acc_r;
    right_acc_nxt = right_acc_r;
    shp_l_nxt     = shp_l_r;
    shp_r_nxt     = shp_r_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) smp_nxt = in_data;
      end
      ST_ACC: begin
        // saturating accumulate
        left_acc_nxt  = sum_l[AccW] ? '1 : sum_l[AccW-1:0];
        right_acc_nxt = sum_r[AccW] ? '1 : sum_r[AccW-1:0];
      end
      ST_FIRE: begin
        fire_l_nxt = fl;
        fire_r_nxt = fr;
        if (fl) left_acc_nxt  = '0;
        if (fr) right_acc_nxt = '0;
        chan_nxt = 1'b0;
        cnt_nxt  = '0;
        rad_nxt  = load_rad(smp_r.left_sample);
        rem_nxt  = '0;
        root_nxt = '0;
      end
      ST_SQRT: begin
        rad_nxt  = {rad_r[RadW-3:0], 2'b00};
        rem_nxt  = (rem_sh >= trial) ? RemW'(rem_sh - trial) : rem_sh[RemW-1:0];
        root_nxt = root_fin;
        cnt_nxt  = cnt_r + 1'b1;
        if (sqrt_last) begin
          if (chan_r) begin
            shp_r_nxt = shaped;
          end else begin
            shp_l_nxt = shaped;
            chan_nxt  = 1'b1;
            cnt_nxt   = '0;
            rad_nxt   = load_rad(smp_r.right_sample);
            rem_nxt   = '0;
            root_nxt  = '0;
          end
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_nxt.left_out  = fire_l_r ? shp_l_r : smp_r.left_sample;
          out_nxt.right_out = fire_r_r ? shp_r_r : smp_r.right_sample;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      chan_r      <= 1'b0;
      fire_l_r    <= 1'b0;
      fire_r_r    <= 1'b0;
      left_acc_r  <= '0;
      right_acc_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      chan_r      <= chan_nxt;
      fire_l_r    <= fire_l_nxt;
      fire_r_r    <= fire_r_nxt;
      left_acc_r  <= left_acc_nxt;
      right_acc_r <= right_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r   <= smp_nxt;
    out_r   <= out_nxt;
    shp_l_r <= shp_l_nxt;
    shp_r_r <= shp_r_nxt;
    rad_r   <= rad_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
  end

  // ---------------------------------------------------------------- config regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= FireThresholdReset;
      link_r <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == AddrLinkChannels[2]) link_r <= pwdata[0];
      else                                 thr_r  <= pwdata;
    end
  end

  always_comb begin
    prdata = (paddr[2] == AddrFireThreshold[2]) ? thr_r : {31'b0, link_r};
  end

  // ---------------------------------------------------------------- outputs
  assign pready    = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------- checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall && state_r == ST_ACC)
    else $error("beat accepted but sequencer did not start");

  a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIRE && fl |=> left_acc_r == '0 && fire_l_r)
    else $error("left firing did not clear accumulator");

  a_link_both: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQRT && link_r |-> fire_l_r == fire_r_r)
    else $error("linked mode fired one channel only");

  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQRT |-> rem_r <= {root_r, 1'b0})
    else $error("root remainder out of range");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE && out_free |=> out_valid && state_r == ST_IDLE)
    else $error("result not loaded on write");

endmodule
